>>> rtl/core/esr_pkg.sv
package esr_pkg;

  // Command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_CALIB = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_MIN_PULSE     = 3'd0;
  localparam logic [2:0] REG_MAX_PULSE     = 3'd1;
  localparam logic [2:0] REG_NEUTRAL_PULSE = 3'd2;
  localparam logic [2:0] REG_RAMP_STEP     = 3'd3;
  localparam logic [2:0] REG_CALIB_HOLD    = 3'd4;

  typedef enum logic [1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_STARTING = 2'd1,
    MODE_RUNNING  = 2'd2,
    MODE_CALIB    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SPEED = 2'd1,
    ST_NOT_CAL   = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  // Reset values of the configuration registers
  localparam logic [15:0] MIN_PULSE_RST     = 16'd1000;
  localparam logic [15:0] MAX_PULSE_RST     = 16'd2000;
  localparam logic [15:0] NEUTRAL_PULSE_RST = 16'd1500;
  localparam logic [19:0] RAMP_STEP_RST     = 20'd500;
  localparam logic [15:0] CALIB_HOLD_RST    = 16'd2000;

  localparam logic [13:0] SPEED_REQ_MAX = 14'd10000;
  localparam logic [20:0] FINE_PER_REQ  = 21'd100;

  // x / 625 == (x * DIV625_MUL) >> 36, exact for x < 2^26
  localparam logic [26:0] DIV625_MUL = 27'd109951163;
  // x / 25 == (x * DIV25_MUL) >> 23, exact for x < 2^18
  localparam logic [18:0] DIV25_MUL  = 19'd335545;

  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;
    logic [19:0] ramp_step;
    logic [15:0] calib_hold;
  } cfg_t;

  // Item after the first stage: products formed, flags decoded
  typedef struct packed {
    logic [2:0]  cmd;
    logic        req_bad;
    logic        req_zero;
    logic [19:0] tgt_fine;
    logic [15:0] ms;
    logic [35:0] lim;
    logic        span_neg;
    logic [29:0] prod;
  } pre_t;

  // Item entering the state update: mapped pulse ready
  typedef struct packed {
    logic [2:0]  cmd;
    logic        req_bad;
    logic        req_zero;
    logic [19:0] tgt_fine;
    logic [15:0] ms;
    logic [35:0] lim;
    logic [15:0] pulse;
  } work_t;

  // State after the update, as seen by the result
  typedef struct packed {
    status_t     status;
    logic [15:0] pulse;
    logic        enabled;
    mode_t       mode;
    logic [19:0] speed_fine;
    logic        calibrated;
  } upd_t;

endpackage

>>> rtl/core/esr_if.sv
interface esr_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [13:0] speed_request;
  logic [15:0] elapsed_ms;

  modport source(output valid, command, speed_request, elapsed_ms, input ready);
  modport sink(input valid, command, speed_request, elapsed_ms, output ready);
endinterface

interface esr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] pulse_width;
  logic        pwm_enabled;
  logic [1:0]  motor_mode;
  logic [13:0] present_speed;
  logic        is_calibrated;

  modport source(output valid, status, pulse_width, pwm_enabled, motor_mode,
                 present_speed, is_calibrated, input ready);
  modport sink(input valid, status, pulse_width, pwm_enabled, motor_mode,
               present_speed, is_calibrated, output ready);
endinterface

interface esr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/esr_state.sv
module esr_state (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  esr_pkg::cfg_t  cfg,
  input  esr_pkg::work_t item,
  output esr_pkg::upd_t  upd
);
  import esr_pkg::*;

  mode_t       mode, mode_next;
  logic [19:0] target, target_next;
  logic [19:0] speed, speed_next;
  logic [15:0] pulse, pulse_next;
  logic        enabled, enabled_next;
  logic        calibrated, calibrated_next;
  logic        phase, phase_next;
  logic [16:0] timer, timer_next;
  status_t     status;

  logic [16:0] timer_sum;
  logic [19:0] up_diff;
  logic [19:0] dn_diff;

  always_comb begin
    mode_next       = mode;
    target_next     = target;
    speed_next      = speed;
    pulse_next      = pulse;
    enabled_next    = enabled;
    calibrated_next = calibrated;
    phase_next      = phase;
    timer_next      = timer;
    status          = ST_OK;

    timer_sum = timer + {1'b0, item.ms};
    up_diff   = target - speed;
    dn_diff   = speed - target;

    if (item.cmd == CMD_TICK) begin
      case (mode)
        MODE_CALIB: begin
          if (timer_sum >= {1'b0, cfg.calib_hold}) begin
            // Phase done: drop excess time, drive the low level
            timer_next = '0;
            pulse_next = cfg.min_pulse;
            if (phase) begin
              phase_next      = 1'b0;
              calibrated_next = 1'b1;
              mode_next       = MODE_STOPPED;
            end else begin
              phase_next = 1'b1;
            end
          end else begin
            timer_next = timer_sum;
          end
        end
        MODE_RUNNING: begin
          if (target > speed && {16'd0, up_diff} > item.lim) begin
            speed_next = speed + item.lim[19:0];
          end else if (speed > target && {16'd0, dn_diff} > item.lim) begin
            speed_next = speed - item.lim[19:0];
          end else begin
            speed_next = target;
          end
        end
        MODE_STOPPED: begin
          speed_next = '0;
        end
        default: begin
        end
      endcase
    end else if (item.cmd <= CMD_CALIB && mode == MODE_CALIB) begin
      status = ST_BUSY;
    end else begin
      case (item.cmd)
        CMD_SET: begin
          if (item.req_bad) begin
            status = ST_BAD_SPEED;
          end else if (!calibrated && !item.req_zero) begin
            status = ST_NOT_CAL;
          end else begin
            target_next = item.tgt_fine;
            if (item.req_zero) begin
              mode_next  = MODE_STOPPED;
              pulse_next = cfg.min_pulse;
            end else begin
              mode_next  = MODE_RUNNING;
              pulse_next = item.pulse;
            end
          end
        end
        CMD_START: begin
          enabled_next = 1'b1;
          mode_next    = MODE_STARTING;
        end
        CMD_STOP: begin
          mode_next    = MODE_STOPPED;
          target_next  = '0;
          speed_next   = '0;
          pulse_next   = cfg.min_pulse;
          enabled_next = 1'b0;
        end
        CMD_CALIB: begin
          mode_next  = MODE_CALIB;
          pulse_next = cfg.max_pulse;
          phase_next = 1'b0;
          timer_next = '0;
        end
        default: begin
        end
      endcase
    end

    upd.status     = status;
    upd.pulse      = pulse_next;
    upd.enabled    = enabled_next;
    upd.mode       = mode_next;
    upd.speed_fine = speed_next;
    upd.calibrated = calibrated_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_STOPPED;
      target     <= '0;
      speed      <= '0;
      pulse      <= NEUTRAL_PULSE_RST;
      enabled    <= 1'b0;
      calibrated <= 1'b0;
      phase      <= 1'b0;
      timer      <= '0;
    end else if (en) begin
      mode       <= mode_next;
      target     <= target_next;
      speed      <= speed_next;
      pulse      <= pulse_next;
      enabled    <= enabled_next;
      calibrated <= calibrated_next;
      phase      <= phase_next;
      timer      <= timer_next;
    end
  end

endmodule

>>> rtl/core/esc_speed_ramp_controller.sv
// Throttle controller for a pulse-driven motor with a slew-rate limited speed.
// Channels: cmd takes one command per transaction (tick with elapsed
// milliseconds, set speed, start, stop, calibrate); res returns exactly one
// result per command with the status and the state after it (pulse width,
// output enable, mode, ramped speed in 0.01 %, calibration flag); cfg writes
// the configuration registers by index and is always ready.
// Pipeline: a command passes through four registered stages to its result.
// The stages are: products (ramp limit, pulse span), constant division of
// the pulse span, state update, speed scaling to 0.01 % units.
// Throughput: one command per cycle. Each stage holds one transaction and
// advances whenever the stage after it is empty or advancing, so the input
// keeps taking commands while a finished result waits at the output.
// When the receiver stalls, results hold in the output register and the
// stages fill; cmd.ready drops only once all four stages are full.
// Reset: mode stopped, speeds zero, pulse at the neutral reset width,
// output disabled, not calibrated, configuration at its reset values.
// A write to the neutral pulse register has no effect on the pulse.
// Write configuration only with no command in flight.
module esc_speed_ramp_controller (
  input logic   clk,
  input logic   rst,
  esr_cmd_if.sink   cmd,
  esr_res_if.source res,
  esr_cfg_if.sink   cfg
);
  import esr_pkg::*;

  cfg_t cfg_reg;

  // Stage valids and stage-ready chain
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  pre_t  s1, s1_next;
  work_t s2, s2_next;
  upd_t  s3, upd;
  upd_t  s4, s4_next;

  logic [16:0] span;
  logic [15:0] span_mag;
  logic [25:0] div_in;
  logic [52:0] div_prod;
  logic [15:0] quot;
  logic [36:0] spd_prod;
  logic [20:0] tgt_wide;

  // Configuration: always ready, store by index
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.min_pulse  <= MIN_PULSE_RST;
      cfg_reg.max_pulse  <= MAX_PULSE_RST;
      cfg_reg.ramp_step  <= RAMP_STEP_RST;
      cfg_reg.calib_hold <= CALIB_HOLD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MIN_PULSE:  cfg_reg.min_pulse  <= cfg.data[15:0];
        REG_MAX_PULSE:  cfg_reg.max_pulse  <= cfg.data[15:0];
        REG_RAMP_STEP:  cfg_reg.ramp_step  <= cfg.data;
        REG_CALIB_HOLD: cfg_reg.calib_hold <= cfg.data[15:0];
        // Neutral pulse only matters at reset; drop the write
        REG_NEUTRAL_PULSE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake chain: a stage advances when empty or when its successor does
  assign rdy4      = !v4 || res.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign cmd.ready = rdy1;

  // Stage 1: ramp limit, pulse span magnitude times request, target speed
  always_comb begin
    span     = {1'b0, cfg_reg.max_pulse} - {1'b0, cfg_reg.min_pulse};
    span_mag = span[16] ? 16'(-span) : span[15:0];
    tgt_wide = {7'd0, cmd.speed_request} * FINE_PER_REQ;

    s1_next.cmd      = cmd.command;
    s1_next.req_bad  = cmd.speed_request > SPEED_REQ_MAX;
    s1_next.req_zero = cmd.speed_request == '0;
    s1_next.tgt_fine = tgt_wide[19:0];
    s1_next.ms       = cmd.elapsed_ms;
    s1_next.lim      = {16'd0, cfg_reg.ramp_step} * {20'd0, cmd.elapsed_ms};
    s1_next.span_neg = span[16];
    s1_next.prod     = {16'd0, cmd.speed_request} * {14'd0, span_mag};
  end

  // Stage 2: divide the span product by 10000 (shift by 4, then by 625)
  always_comb begin
    div_in   = s1.prod[29:4];
    div_prod = {27'd0, div_in} * {26'd0, DIV625_MUL};
    quot     = div_prod[51:36];

    s2_next.cmd      = s1.cmd;
    s2_next.req_bad  = s1.req_bad;
    s2_next.req_zero = s1.req_zero;
    s2_next.tgt_fine = s1.tgt_fine;
    s2_next.ms       = s1.ms;
    s2_next.lim      = s1.lim;
    s2_next.pulse    = s1.span_neg ? cfg_reg.min_pulse - quot
                                   : cfg_reg.min_pulse + quot;
  end

  // Stage 3: state update, one command at a time in arrival order
  esr_state u_state (
    .clk  (clk),
    .rst  (rst),
    .en   (v2 && rdy3),
    .cfg  (cfg_reg),
    .item (s2),
    .upd  (upd)
  );

  // Stage 4: speed in 0.0001 % to 0.01 % (shift by 2, then divide by 25)
  always_comb begin
    spd_prod   = {19'd0, s3.speed_fine[19:2]} * {18'd0, DIV25_MUL};
    s4_next    = s3;
    s4_next.speed_fine = {6'd0, spd_prod[36:23]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= cmd.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Payload registers: load only when a transaction moves in
  always_ff @(posedge clk) begin
    if (rdy1 && cmd.valid) s1 <= s1_next;
    if (rdy2 && v1)        s2 <= s2_next;
    if (rdy3 && v2)        s3 <= upd;
    if (rdy4 && v3)        s4 <= s4_next;
  end

  assign res.valid         = v4;
  assign res.status        = s4.status;
  assign res.pulse_width   = s4.pulse;
  assign res.pwm_enabled   = s4.enabled;
  assign res.motor_mode    = s4.mode;
  assign res.present_speed = s4.speed_fine[13:0];
  assign res.is_calibrated = s4.calibrated;

endmodule

>>> sim/esc_speed_ramp_controller_test.sv
module esc_speed_ramp_controller_test;
  import esr_pkg::*;

  localparam logic [19:0] FULL_SPEED_FINE = 20'd1000000;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 80;

  // One result as the block should report it after a command.
  typedef struct {
    status_t     status;
    logic [15:0] pulse_width;
    logic        pwm_enabled;
    mode_t       motor_mode;
    logic [13:0] present_speed;
    logic        is_calibrated;
  } throttle_report_t;

  // Tracks the throttle state on its own and queues the report each command
  // should produce; results are matched in order.
  class throttle_tracker;
    logic [15:0] min_pulse, max_pulse, neutral_pulse, calib_hold;
    logic [19:0] ramp_step;
    mode_t       mode;
    logic [19:0] target_fine, speed_fine;
    logic [15:0] pulse;
    logic        enabled, calibrated, calib_low_phase;
    logic [16:0] calib_timer;
    throttle_report_t pending_reports[$];
    int errors;

    function new();
      min_pulse = MIN_PULSE_RST;
      max_pulse = MAX_PULSE_RST;
      neutral_pulse = NEUTRAL_PULSE_RST;
      ramp_step = RAMP_STEP_RST;
      calib_hold = CALIB_HOLD_RST;
      mode = MODE_STOPPED;
      target_fine = '0;
      speed_fine = '0;
      pulse = NEUTRAL_PULSE_RST;
      enabled = 1'b0;
      calibrated = 1'b0;
      calib_low_phase = 1'b0;
      calib_timer = '0;
      errors = 0;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void write_reg(logic [2:0] index, logic [19:0] data);
      case (index)
        REG_MIN_PULSE: min_pulse = data[15:0];
        // The pulse register only loads this value at reset.
        REG_NEUTRAL_PULSE: neutral_pulse = data[15:0];
        REG_MAX_PULSE: max_pulse = data[15:0];
        REG_RAMP_STEP: ramp_step = data;
        REG_CALIB_HOLD: calib_hold = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [2:0] op, logic [13:0] req, logic [15:0] ms);
      status_t st;
      logic [63:0] lim, cur, tgt;
      longint span, prod;
      throttle_report_t r;
      st = ST_OK;
      if (op == CMD_TICK) begin
        case (mode)
          MODE_CALIB: begin
            calib_timer = calib_timer + ms;
            if (calib_timer >= calib_hold) begin
              // End the phase, drop any excess time.
              calib_timer = '0;
              pulse = min_pulse;
              if (!calib_low_phase) begin
                calib_low_phase = 1'b1;
              end else begin
                calib_low_phase = 1'b0;
                calibrated = 1'b1;
                mode = MODE_STOPPED;
              end
            end
          end
          MODE_RUNNING: begin
            // Slew toward the target by at most ramp_step per ms.
            lim = 64'(ramp_step) * 64'(ms);
            cur = 64'(speed_fine);
            tgt = 64'(target_fine);
            if (tgt > cur && tgt - cur > lim) cur = cur + lim;
            else if (cur > tgt && cur - tgt > lim) cur = cur - lim;
            else cur = tgt;
            if (cur > 64'(FULL_SPEED_FINE)) cur = 64'(FULL_SPEED_FINE);
            speed_fine = cur[19:0];
          end
          MODE_STOPPED: speed_fine = '0;
          default: ;
        endcase
      end else if (op <= CMD_CALIB && mode == MODE_CALIB) begin
        st = ST_BUSY;
      end else if (op == CMD_SET) begin
        if (req > SPEED_REQ_MAX) begin
          st = ST_BAD_SPEED;
        end else if (!calibrated && req != '0) begin
          st = ST_NOT_CAL;
        end else begin
          target_fine = 20'(req) * 20'd100;
          if (req == '0) begin
            mode = MODE_STOPPED;
            pulse = min_pulse;
          end else begin
            // Signed span, division truncates toward zero, sum wraps.
            mode = MODE_RUNNING;
            span = longint'(max_pulse) - longint'(min_pulse);
            prod = (longint'(req) * span) / 10000;
            pulse = 16'(longint'(min_pulse) + prod);
          end
        end
      end else if (op == CMD_START) begin
        enabled = 1'b1;
        mode = MODE_STARTING;
      end else if (op == CMD_STOP) begin
        mode = MODE_STOPPED;
        target_fine = '0;
        speed_fine = '0;
        pulse = min_pulse;
        enabled = 1'b0;
      end else if (op == CMD_CALIB) begin
        mode = MODE_CALIB;
        pulse = max_pulse;
        calib_low_phase = 1'b0;
        calib_timer = '0;
      end
      r.status = st;
      r.pulse_width = pulse;
      r.pwm_enabled = enabled;
      r.motor_mode = mode;
      r.present_speed = 14'(speed_fine / 20'd100);
      r.is_calibrated = calibrated;
      pending_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] pw, logic en, logic [1:0] md,
                               logic [13:0] sp, logic cal);
      throttle_report_t r;
      if (pending_reports.size() == 0) begin
        $error("result with no command outstanding: status %0d pulse %0d", st, pw);
        errors++;
        return;
      end
      r = pending_reports.pop_front();
      compare_field("status", 16'(r.status), 16'(st));
      compare_field("pulse_width", r.pulse_width, pw);
      compare_field("pwm_enabled", 16'(r.pwm_enabled), 16'(en));
      compare_field("motor_mode", 16'(r.motor_mode), 16'(md));
      compare_field("present_speed", 16'(r.present_speed), 16'(sp));
      compare_field("is_calibrated", 16'(r.is_calibrated), 16'(cal));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  esr_cmd_if cmd_if();
  esr_res_if res_if();
  esr_cfg_if cfg_if();

  esc_speed_ramp_controller dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  throttle_tracker tracker = new();

  int burst_left;
  int hold_requests;

  always #5 clk = ~clk;

  // Check every result transaction against the oldest queued report.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      tracker.check_result(res_if.status, res_if.pulse_width, res_if.pwm_enabled,
                           res_if.motor_mode, res_if.present_speed, res_if.is_calibrated);
    end
  end

  // Receiver: switch between stall styles on its own schedule, and hold off
  // for a long stretch whenever the stimulus asks for back-pressure.
  initial begin
    int style, style_left, hold_left, holds_done;
    style = 0;
    style_left = 0;
    hold_left = 0;
    holds_done = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        style = $urandom_range(3);
        style_left = $urandom_range(30, 200);
      end
      style_left--;
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (style)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(1));
          2: res_if.ready <= ($urandom_range(7) != 0);
          default: res_if.ready <= (style_left[1:0] != 2'd0);
        endcase
      end
    end
  end

  // Offer one command; keep valid high across a burst, drop it for a gap
  // between some bursts. Note the command once its transaction completes.
  task automatic push_command(logic [2:0] op, logic [13:0] req, logic [15:0] ms);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_if.valid <= 1'b1;
    cmd_if.command <= op;
    cmd_if.speed_request <= req;
    cmd_if.elapsed_ms <= ms;
    do @(posedge clk); while (!cmd_if.ready);
    tracker.note_command(op, req, ms);
  endtask

  // Mostly ticks and legal set-speed requests so that calibration completes
  // and the ramp runs; also start, stop, calibrate, unknown ops, bad speeds.
  task automatic send_random_command();
    int pick;
    logic [2:0] op;
    logic [13:0] req;
    logic [15:0] ms;
    pick = $urandom_range(99);
    if (pick < 42) op = CMD_TICK;
    else if (pick < 72) op = CMD_SET;
    else if (pick < 82) op = CMD_START;
    else if (pick < 88) op = CMD_STOP;
    else if (pick < 97) op = CMD_CALIB;
    else op = 3'($urandom_range(5, 7));
    pick = $urandom_range(99);
    if (pick < 8) req = '0;
    else if (pick < 14) req = SPEED_REQ_MAX;
    else if (pick < 80) req = 14'($urandom_range(10000));
    else req = 14'($urandom_range(16383, 10001));
    pick = $urandom_range(99);
    if (pick < 8) ms = '0;
    else if (pick < 70) ms = 16'($urandom_range(20));
    else if (pick < 90) ms = 16'($urandom_range(2000));
    else ms = 16'($urandom_range(65535));
    push_command(op, req, ms);
  endtask

  // Write one register; valid stays high for a following write.
  task automatic write_reg(logic [2:0] index, logic [19:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    tracker.write_reg(index, data);
  endtask

  // Drop the command valid and wait until every result has come back.
  task automatic drain();
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] min_p, logic [15:0] max_p, logic [15:0] neutral_p,
                           logic [19:0] ramp, logic [15:0] hold);
    write_reg(REG_MIN_PULSE, 20'(min_p));
    write_reg(REG_MAX_PULSE, 20'(max_p));
    write_reg(REG_NEUTRAL_PULSE, 20'(neutral_p));
    write_reg(REG_RAMP_STEP, ramp);
    write_reg(REG_CALIB_HOLD, 20'(hold));
    cfg_if.valid <= 1'b0;
  endtask

  // Time limit on the whole run.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int phase, n;
    burst_left = 0;
    hold_requests = 0;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_TICK;
    cmd_if.speed_request = '0;
    cmd_if.elapsed_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MIN_PULSE;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at reset configuration.
    push_command(CMD_TICK, 14'd0, 16'd0);          // neutral pulse still driven
    push_command(CMD_SET, 14'd5000, 16'd0);        // refused: not calibrated
    push_command(CMD_SET, 14'd10001, 16'd0);       // refused: just above full
    push_command(CMD_SET, 14'h3FFF, 16'hFFFF);     // refused: largest request
    push_command(CMD_SET, 14'd0, 16'd0);           // zero is allowed uncalibrated
    push_command(CMD_START, 14'd0, 16'd0);
    push_command(CMD_TICK, 14'd0, 16'd100);        // starting mode holds still
    push_command(CMD_CALIB, 14'd0, 16'd0);
    push_command(CMD_SET, 14'd100, 16'd0);         // busy while calibrating
    push_command(CMD_START, 14'd0, 16'd0);
    push_command(CMD_STOP, 14'd0, 16'd0);
    push_command(CMD_CALIB, 14'd0, 16'd0);
    push_command(3'd5, 14'd0, 16'd0);              // unknown: no effect
    push_command(3'd7, 14'h3FFF, 16'hFFFF);
    push_command(CMD_TICK, 14'd0, 16'd1999);       // one short of the hold
    push_command(CMD_TICK, 14'd0, 16'd1);          // high phase ends
    push_command(CMD_TICK, 14'd0, 16'hFFFF);       // low phase ends, excess dropped
    push_command(CMD_SET, SPEED_REQ_MAX, 16'd0);   // full throttle
    push_command(CMD_TICK, 14'd0, 16'd1);
    push_command(CMD_TICK, 14'd0, 16'hFFFF);       // reaches target at once
    push_command(CMD_SET, 14'd1, 16'd0);
    push_command(CMD_TICK, 14'd0, 16'd0);          // zero elapsed, no movement
    push_command(CMD_TICK, 14'd0, 16'd3);
    push_command(CMD_SET, 14'd0, 16'd0);           // zero speed stops
    push_command(CMD_START, 14'd0, 16'd0);
    push_command(CMD_STOP, 14'd0, 16'd0);
    push_command(3'd6, 14'd0, 16'd0);
    for (n = 0; n < 60; n++) send_random_command();

    // Walk through configurations: extremes first, then random settings.
    for (phase = 1; phase <= 7; phase++) begin
      drain();
      case (phase)
        1: configure(16'd0, 16'hFFFF, 16'd0, 20'd0, 16'd0);
        2: configure(16'hFFFF, 16'd0, 16'hFFFF, 20'd1000000, 16'd1);
        3: configure(16'd1000, 16'd2000, 16'd1234, 20'hFFFFF, 16'hFFFF);
        default: configure(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                           16'($urandom_range(65535)), 20'($urandom_range(1, 30000)),
                           16'($urandom_range(40)));
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Stall the receiver long enough to fill the pipeline and block input.
        if ((phase == 2 || phase == 5) && n == 20) hold_requests <= hold_requests + 1;
        send_random_command();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
